[design/nicu_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the Newton implicit cell update block.
// No dependencies.
package nicu_pkg;

    typedef enum logic [1:0] {
        REG_STEP_RATIO = 2'd0,
        REG_TOLERANCE  = 2'd1,
        REG_ITER_CAP   = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_CONV = 2'd0,
        ST_CAP  = 2'd1,
        ST_ZDER = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PREP,
        DP_K1,
        DP_K2,
        DP_K3,
        DP_K4,
        DP_K5,
        DP_F1,
        DP_F2,
        DP_F3,
        DP_DIV_START,
        DP_UPDATE,
        DP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_K1,
        S_K2,
        S_K3,
        S_K4,
        S_K5,
        S_F1,
        S_F2,
        S_F3,
        S_CHECK,
        S_DIV,
        S_TEST,
        S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t  op;
        logic    set_code;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic dfx_zero;
        logic div_done;
        logic converged;
        logic cap_reached;
        logic out_free;
    } dp_stat_t;

    localparam int CAP_WIDTH = 8;
    localparam int CFG_WIDTH = 31;

endpackage

[design/nicu_if.sv]
`timescale 1ns / 1ps
// Word channels of the cell update block: input cell words and result words.
// No dependencies.
interface nicu_in_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] left_new;
    logic signed [VALUE_WIDTH-1:0] here_old;
    logic signed [VALUE_WIDTH-1:0] right_old;

    modport source (output valid, left_new, here_old, right_old, input ready);
    modport sink   (input valid, left_new, here_old, right_old, output ready);
endinterface

interface nicu_out_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] cell_value;
    logic [7:0]                    steps_taken;
    logic [1:0]                    status;

    modport source (output valid, cell_value, steps_taken, status, input ready);
    modport sink   (input valid, cell_value, steps_taken, status, output ready);
endinterface

[design/nicu_div.sv]
`timescale 1ns / 1ps
// Restoring fixed-point divider, one quotient bit per cycle, saturating result.
// Depends on nothing beyond its parameters.
module nicu_div #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [VALUE_WIDTH-1:0] num,
    input  logic signed [VALUE_WIDTH-1:0] den,
    output logic                          done,
    output logic signed [VALUE_WIDTH-1:0] quot,
    output logic                          sat
);
    localparam int W  = VALUE_WIDTH;
    localparam int QW = VALUE_WIDTH + FRACTION_BITS;
    localparam int CW = $clog2(QW + 1);
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0] dvd_reg, dvd_next;
    logic [QW-1:0] q_reg, q_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  d_reg, d_next;
    logic          neg_reg, neg_next;

    logic [W:0]    rem_sh;
    logic          ge;
    logic [W-1:0]  n_mag, d_mag;

    assign n_mag  = num[W-1] ? W'(-num) : W'(num);
    assign d_mag  = den[W-1] ? W'(-den) : W'(den);
    assign rem_sh = {rem_reg, dvd_reg[QW-1]};
    assign ge     = rem_sh >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            dvd_next  = {n_mag, {FRACTION_BITS{1'b0}}};
            q_next    = '0;
            rem_next  = '0;
            d_next    = d_mag;
            neg_next  = num[W-1] ^ den[W-1];
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[QW-2:0], 1'b0};
            q_next   = {q_reg[QW-2:0], ge};
            rem_next = ge ? W'(rem_sh - {1'b0, d_reg}) : rem_sh[W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        sat  = 1'b0;
        quot = VMAX;
        if (!neg_reg)
        begin
            if (q_reg > QW'(VMAX))
            begin
                sat  = 1'b1;
                quot = VMAX;
            end
            else
                quot = q_reg[W-1:0];
        end
        else
        begin
            if (q_reg > QW'(VMIN))
            begin
                sat  = 1'b1;
                quot = VMIN;
            end
            else
                quot = W'(-q_reg[W-1:0]);
        end
    end

    assign done = done_reg;
endmodule

[design/nicu_dpath.sv]
`timescale 1ns / 1ps
// Datapath: operand registers, shared saturating multiplier, divider, result word.
// Depends on nicu_pkg and nicu_div.
module nicu_dpath
    import nicu_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_cmd_t                       cmd,
    output dp_stat_t                      stat,
    input  logic [CFG_WIDTH-1:0]          step_ratio,
    input  logic [CFG_WIDTH-1:0]          tolerance,
    input  logic [CAP_WIDTH-1:0]          iteration_cap,
    input  logic signed [VALUE_WIDTH-1:0] left_new,
    input  logic signed [VALUE_WIDTH-1:0] here_old,
    input  logic signed [VALUE_WIDTH-1:0] right_old,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0] cell_value,
    output logic [CAP_WIDTH-1:0]          steps_taken,
    output logic [1:0]                    status
);
    localparam int W    = VALUE_WIDTH;
    localparam int CMPW = (W > CFG_WIDTH + 1) ? W : CFG_WIDTH + 1;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W:0] sat_add(input logic [W-1:0] p, input logic [W-1:0] q);
        logic [W:0] s;
        s = {p[W-1], p} + {q[W-1], q};
        if (s[W] != s[W-1])
            return s[W] ? {1'b1, VMIN} : {1'b1, VMAX};
        return {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W:0] sat_sub(input logic [W-1:0] p, input logic [W-1:0] q);
        logic [W:0] s;
        s = {p[W-1], p} - {q[W-1], q};
        if (s[W] != s[W-1])
            return s[W] ? {1'b1, VMIN} : {1'b1, VMAX};
        return {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? W'(-v) : v;
    endfunction

    logic signed [W-1:0] a_reg, b_reg, c_reg, x_reg, tr_reg, k_reg, acc_reg, dfx_reg;
    logic signed [W-1:0] a_next, b_next, c_next, x_next, tr_next, k_next, acc_next;
    logic signed [W-1:0] dfx_next;
    logic                sat_reg, sat_next;
    logic                conv_reg, conv_next;
    logic [CAP_WIDTH-1:0] steps_reg, steps_next;
    status_t             code_reg, code_next;
    logic                out_valid_reg;
    logic signed [W-1:0] cell_value_reg;
    logic [CAP_WIDTH-1:0] steps_out_reg;
    status_t             status_out_reg;

    logic [W-1:0]   ma, mb, mag_a, mag_b, r_val;
    logic [2*W-1:0] prod, prod_sh;
    logic [W:0]     mres;
    logic [W:0]     t1, t2;
    logic [CMPW-1:0] ratio_w;
    logic [CAP_WIDTH-1:0] cap_eff;
    logic [W-1:0]   dm;
    logic           div_start, div_done, div_sat;
    logic signed [W-1:0] quot;

    always_comb
    begin
        ma = x_reg;
        mb = x_reg;
        case (cmd.op)
            DP_K1:   begin ma = tr_reg; mb = acc_reg; end
            DP_K2:   begin ma = a_reg;  mb = a_reg;   end
            DP_K3:   begin ma = b_reg;  mb = b_reg;   end
            DP_K4:   begin ma = c_reg;  mb = c_reg;   end
            DP_F2:   begin ma = tr_reg; mb = x_reg;   end
            default: begin ma = x_reg;  mb = x_reg;   end
        endcase
    end

    assign mag_a   = mag(ma);
    assign mag_b   = mag(mb);
    assign prod    = {{W{1'b0}}, mag_a} * {{W{1'b0}}, mag_b};
    assign prod_sh = prod >> FRACTION_BITS;

    always_comb
    begin
        if (!(ma[W-1] ^ mb[W-1]))
            mres = (prod_sh > (2*W)'(VMAX)) ? {1'b1, VMAX} : {1'b0, prod_sh[W-1:0]};
        else
            mres = (prod_sh > (2*W)'(VMIN)) ? {1'b1, VMIN} : {1'b0, W'(-prod_sh[W-1:0])};
    end

    assign ratio_w = CMPW'(step_ratio);
    assign r_val   = (ratio_w > CMPW'(VMAX)) ? VMAX : W'(ratio_w);
    assign cap_eff = (iteration_cap == '0) ? CAP_WIDTH'(1) : iteration_cap;
    assign dm      = mag(quot);

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        x_next    = x_reg;
        tr_next   = tr_reg;
        k_next    = k_reg;
        acc_next  = acc_reg;
        dfx_next  = dfx_reg;
        sat_next  = sat_reg;
        conv_next = conv_reg;
        steps_next = steps_reg;
        code_next = cmd.set_code ? cmd.code : code_reg;
        div_start = 1'b0;
        t1 = '0;
        t2 = '0;
        case (cmd.op)
            DP_LOAD:
            begin
                a_next     = left_new;
                b_next     = here_old;
                c_next     = right_old;
                x_next     = here_old;
                sat_next   = 1'b0;
                steps_next = '0;
            end
            DP_PREP:
            begin
                t1       = sat_add(r_val, r_val);
                t2       = sat_sub(a_reg, b_reg);
                tr_next  = t1[W-1:0];
                t2       = {t2[W] | t1[W], t2[W-1:0]};
                t1       = sat_sub(t2[W-1:0], c_reg);
                acc_next = t1[W-1:0];
                sat_next = sat_reg | t1[W] | t2[W];
            end
            DP_K1:
            begin
                k_next   = mres[W-1:0];
                sat_next = sat_reg | mres[W];
            end
            DP_K2, DP_F1:
            begin
                acc_next = mres[W-1:0];
                sat_next = sat_reg | mres[W];
            end
            DP_K3, DP_F2:
            begin
                t1       = sat_add(acc_reg, mres[W-1:0]);
                acc_next = t1[W-1:0];
                sat_next = sat_reg | mres[W] | t1[W];
            end
            DP_K4:
            begin
                t1       = sat_sub(acc_reg, mres[W-1:0]);
                acc_next = t1[W-1:0];
                sat_next = sat_reg | mres[W] | t1[W];
            end
            DP_K5:
            begin
                t1       = sat_sub(k_reg, acc_reg);
                k_next   = t1[W-1:0];
                sat_next = sat_reg | t1[W];
            end
            DP_F3:
            begin
                t1       = sat_add(acc_reg, k_reg);
                acc_next = t1[W-1:0];
                t2       = sat_add(x_reg, x_reg);
                sat_next = sat_reg | t1[W] | t2[W];
                t1       = sat_add(t2[W-1:0], tr_reg);
                dfx_next = t1[W-1:0];
                sat_next = sat_next | t1[W];
            end
            DP_DIV_START:
                div_start = 1'b1;
            DP_UPDATE:
            begin
                t1         = sat_sub(x_reg, quot);
                x_next     = t1[W-1:0];
                sat_next   = sat_reg | t1[W] | div_sat;
                steps_next = steps_reg + 1'b1;
                conv_next  = (dm == '0) || (CMPW'(dm) < CMPW'({tolerance, 1'b0}));
            end
            default:
            begin
                t1 = '0;
            end
        endcase
    end

    nicu_div #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg),
        .den   (dfx_reg),
        .done  (div_done),
        .quot  (quot),
        .sat   (div_sat)
    );

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        x_reg     <= x_next;
        tr_reg    <= tr_next;
        k_reg     <= k_next;
        acc_reg   <= acc_next;
        dfx_reg   <= dfx_next;
        sat_reg   <= sat_next;
        conv_reg  <= conv_next;
        steps_reg <= steps_next;
        code_reg  <= code_next;
        if (cmd.op == DP_OUT)
        begin
            cell_value_reg <= x_reg;
            steps_out_reg  <= steps_reg;
            status_out_reg <= (code_reg != ST_ZDER && sat_reg) ? ST_SAT : code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == DP_OUT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign stat.dfx_zero    = (dfx_reg == '0);
    assign stat.div_done    = div_done;
    assign stat.converged   = conv_reg;
    assign stat.cap_reached = (steps_reg >= cap_eff);
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign cell_value  = cell_value_reg;
    assign steps_taken = steps_out_reg;
    assign status      = status_out_reg;
endmodule

[design/nicu_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences setup, Newton steps and result hand-off.
// Depends on nicu_pkg.
module nicu_ctrl
    import nicu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_PREP;
            S_PREP:  state_next = S_K1;
            S_K1:    state_next = S_K2;
            S_K2:    state_next = S_K3;
            S_K3:    state_next = S_K4;
            S_K4:    state_next = S_K5;
            S_K5:    state_next = S_F1;
            S_F1:    state_next = S_F2;
            S_F2:    state_next = S_F3;
            S_F3:    state_next = S_CHECK;
            S_CHECK: state_next = stat.dfx_zero ? S_DONE : S_DIV;
            S_DIV:   if (stat.div_done) state_next = S_TEST;
            S_TEST:
            begin
                if (stat.converged || stat.cap_reached)
                    state_next = S_DONE;
                else
                    state_next = S_F1;
            end
            S_DONE:  if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.op       = DP_NOP;
        cmd.set_code = 1'b0;
        cmd.code     = ST_CONV;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = DP_LOAD;
            end
            S_PREP:  cmd.op = DP_PREP;
            S_K1:    cmd.op = DP_K1;
            S_K2:    cmd.op = DP_K2;
            S_K3:    cmd.op = DP_K3;
            S_K4:    cmd.op = DP_K4;
            S_K5:    cmd.op = DP_K5;
            S_F1:    cmd.op = DP_F1;
            S_F2:    cmd.op = DP_F2;
            S_F3:    cmd.op = DP_F3;
            S_CHECK:
            begin
                if (stat.dfx_zero)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_ZDER;
                end
                else
                    cmd.op = DP_DIV_START;
            end
            S_DIV:   if (stat.div_done) cmd.op = DP_UPDATE;
            S_TEST:
            begin
                cmd.set_code = 1'b1;
                cmd.code     = stat.converged ? ST_CONV : ST_CAP;
            end
            S_DONE:  if (stat.out_free) cmd.op = DP_OUT;
            default: cmd.op = DP_NOP;
        endcase
    end
endmodule

[design/newton_implicit_cell_update_core.sv]
`timescale 1ns / 1ps
// Top level of the Newton implicit cell update block: config registers,
// controller and datapath. Depends on nicu_pkg, nicu_if, nicu_ctrl, nicu_dpath.
//
// Usage: cell_in carries one word (left_new, here_old, right_old, Q8.24) per
// cell; cell_out returns one word (cell_value, steps_taken, status) per cell.
// The APB port holds step_ratio (0x0), tolerance (0x4), iteration_cap (0x8);
// write only while the block is idle.
// Timing: one cell at a time. After acceptance, setup runs the states PREP and
// K1 to K5; each Newton step then runs F1, F2, F3, CHECK, the divider (one
// quotient bit per cycle, VALUE_WIDTH+FRACTION_BITS bits, 56 at Q8.24) and
// TEST, and the DONE state moves the result into the output register. A zero
// derivative ends its step at CHECK and goes straight to DONE. The next cell
// is taken once the previous result has moved into the output register.
// Reset returns registers to 1.0, 17 and 32 and drops any cell in flight.
// A stalled receiver holds the result word; one finished cell may wait in
// the core behind it, after which cell_in stays not ready.
module newton_implicit_cell_update_core
    import nicu_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    nicu_in_if.sink     cell_in,
    nicu_out_if.source  cell_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [CFG_WIDTH-1:0] step_ratio_reg, tolerance_reg;
    logic [CAP_WIDTH-1:0] cap_reg;
    logic                 wr_en;
    reg_idx_t             idx;
    dp_cmd_t              cmd;
    dp_stat_t             stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ratio_reg <= CFG_WIDTH'(16777216);
            tolerance_reg  <= CFG_WIDTH'(17);
            cap_reg        <= CAP_WIDTH'(32);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_STEP_RATIO: step_ratio_reg <= pwdata[CFG_WIDTH-1:0];
                REG_TOLERANCE:  tolerance_reg  <= pwdata[CFG_WIDTH-1:0];
                REG_ITER_CAP:   cap_reg        <= pwdata[CAP_WIDTH-1:0];
                default:        cap_reg        <= cap_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_STEP_RATIO: prdata = {1'b0, step_ratio_reg};
            REG_TOLERANCE:  prdata = {1'b0, tolerance_reg};
            REG_ITER_CAP:   prdata = {24'd0, cap_reg};
            default:        prdata = '0;
        endcase
    end

    nicu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cell_in.valid),
        .in_ready (cell_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nicu_dpath #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .step_ratio    (step_ratio_reg),
        .tolerance     (tolerance_reg),
        .iteration_cap (cap_reg),
        .left_new      (cell_in.left_new),
        .here_old      (cell_in.here_old),
        .right_old     (cell_in.right_old),
        .out_valid     (cell_out.valid),
        .out_ready     (cell_out.ready),
        .cell_value    (cell_out.cell_value),
        .steps_taken   (cell_out.steps_taken),
        .status        (cell_out.status)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_in.valid && cell_in.ready) |=> !cell_in.ready)
        else $error("cell word accepted while another is in progress");

    a_zero_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_out.valid && cell_out.steps_taken == 8'd0) |-> (cell_out.status == ST_ZDER))
        else $error("result with no Newton step but not a zero derivative");

    a_update_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_UPDATE) |-> stat.div_done)
        else $error("iterate updated before the divider finished");
endmodule
